FILE: design/rce_pkg.sv
// ----------------------------------------------------------------------------
// rce_pkg: shared types and constants for the range contraction encoder.
// Holds the width codes, the controller state type and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rce_pkg;

	// Element width codes, shared by the input register and the result.
	localparam logic [1:0] W8  = 2'd0;
	localparam logic [1:0] W16 = 2'd1;
	localparam logic [1:0] W32 = 2'd2;
	localparam logic [1:0] W64 = 2'd3;

	// Register map: word index of the element width register.
	localparam logic REG_ELEMENT_WIDTH = 1'b0;

	// Controller states.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CALC,
		ST_EMIT
	} rce_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;     // Accept one element into the block.
		logic calc;      // Work out range, width and offset; start a new block.
		logic rd_issue;  // Read the next stored element.
		logic out_load;  // Move the read element into the output register.
	} rce_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rd_done;   // Every stored element has been read.
		logic rd_last;   // The element in the read register is the last one.
	} rce_status_t;

	// Mask that keeps the bits of one width code.
	function automatic logic [63:0] width_mask(input logic [1:0] code);
		logic [63:0] m;
		case (code)
			W8:      m = 64'h0000_0000_0000_00FF;
			W16:     m = 64'h0000_0000_0000_FFFF;
			W32:     m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

FILE: design/rce_ctrl.sv
// ----------------------------------------------------------------------------
// rce_ctrl: controller of the range contraction encoder.
// Sequences loading, the range calculation and the emission of one block,
// and owns the read and output register valid flags.
// ----------------------------------------------------------------------------
module rce_ctrl import rce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        block_end,
	output logic        in_ready,
	input  logic        out_ready,
	output logic        out_valid,
	input  rce_status_t status,
	output rce_cmd_t    cmd
);

	rce_state_t state_q, state_d;
	logic       rd_pend_q, rd_pend_d;
	logic       out_valid_q, out_valid_d;

	// State and flag registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_pend_q   <= rd_pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready  = 1'b1;
				cmd.store = in_valid;
				if (in_valid && block_end) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				// The output register takes the read data when it is free or
				// its result transfers in this cycle.
				cmd.out_load = rd_pend_q && (!out_valid_q || out_ready);
				cmd.rd_issue = !status.rd_done && (!rd_pend_q || cmd.out_load);
				if (cmd.out_load && status.rd_last) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Valid flags of the read register and the output register.
	always_comb begin
		rd_pend_d   = cmd.rd_issue || (rd_pend_q && !cmd.out_load);
		out_valid_d = cmd.out_load || (out_valid_q && !out_ready);
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/rce_datapath.sv
// ----------------------------------------------------------------------------
// rce_datapath: datapath of the range contraction encoder.
// Element memory, running minimum and maximum, width selection and the
// output register that carries one result.
// ----------------------------------------------------------------------------
module rce_datapath import rce_pkg::*; #(
	parameter int BLOCK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rce_cmd_t    cmd,
	output rce_status_t status,
	input  logic [1:0]  element_width,
	input  logic [63:0] sample_value,
	output logic [63:0] packed_value,
	output logic [1:0]  new_width,
	output logic [63:0] block_minimum,
	output logic [63:0] block_maximum,
	output logic        final_result
);

	localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
	localparam int CW = $clog2(BLOCK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(BLOCK_DEPTH);

	logic [63:0]   mem [BLOCK_DEPTH];
	logic [CW-1:0] count_q;
	logic [63:0]   min_q, max_q;
	logic [CW-1:0] n_q, rd_idx_q;
	logic [63:0]   rdata_q;
	logic          rd_last_q;
	logic [1:0]    nw_q;
	logic          contract_q;
	logic [63:0]   mn_q, mx_q;
	logic [63:0]   masked;
	logic          has_room;
	logic [63:0]   range;
	logic [1:0]    pick;

	assign masked   = sample_value & width_mask(element_width);
	assign has_room = count_q < DEPTH_C;

	// Element memory: one write port while loading, one read port while emitting.
	always_ff @(posedge clk) begin
		if (cmd.store && has_room) begin
			mem[count_q[AW-1:0]] <= masked;
		end
		if (cmd.rd_issue) begin
			rdata_q <= mem[rd_idx_q[AW-1:0]];
		end
	end

	// Narrowest width below the input width that holds the range, else the input width.
	always_comb begin
		range = max_q - min_q;
		if (element_width != W8 && range <= 64'h0000_0000_0000_00FF) begin
			pick = W8;
		end else if ((element_width == W32 || element_width == W64)
				&& range <= 64'h0000_0000_0000_FFFF) begin
			pick = W16;
		end else if (element_width == W64 && range <= 64'h0000_0000_FFFF_FFFF) begin
			pick = W32;
		end else begin
			pick = element_width;
		end
	end

	// Block accumulation, width decision and read sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			min_q      <= '0;
			max_q      <= '0;
			n_q        <= '0;
			rd_idx_q   <= '0;
			rd_last_q  <= 1'b0;
			nw_q       <= W64;
			contract_q <= 1'b0;
			mn_q       <= '0;
			mx_q       <= '0;
		end else begin
			if (cmd.store && has_room) begin
				count_q <= count_q + CW'(1);
				if (count_q == '0) begin
					min_q <= masked;
					max_q <= masked;
				end else begin
					if (masked < min_q) min_q <= masked;
					if (masked > max_q) max_q <= masked;
				end
			end
			if (cmd.calc) begin
				n_q      <= count_q;
				rd_idx_q <= '0;
				count_q  <= '0;
				min_q    <= '0;
				max_q    <= '0;
				if (element_width == W8) begin
					// Eight-bit input passes unchanged with a fixed full range.
					nw_q       <= W8;
					contract_q <= 1'b0;
					mn_q       <= '0;
					mx_q       <= 64'd255;
				end else begin
					nw_q       <= pick;
					contract_q <= pick != element_width;
					mn_q       <= min_q;
					mx_q       <= max_q;
				end
			end
			if (cmd.rd_issue) begin
				rd_idx_q  <= rd_idx_q + CW'(1);
				rd_last_q <= (rd_idx_q + CW'(1)) == n_q;
			end
		end
	end

	// Output register: one result waiting for its transfer.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			packed_value  <= contract_q ? ((rdata_q - mn_q) & width_mask(nw_q)) : rdata_q;
			new_width     <= nw_q;
			block_minimum <= mn_q;
			block_maximum <= mx_q;
			final_result  <= rd_last_q;
		end
	end

	assign status.rd_done = rd_idx_q == n_q;
	assign status.rd_last = rd_last_q;

endmodule

FILE: design/range_contraction_encoder_core.sv
// ----------------------------------------------------------------------------
// range_contraction_encoder_core: frame-of-reference block encoder.
// Loads a block of elements, then emits each one offset by the block minimum
// at the narrowest smaller width that holds the block range, else unchanged.
//
//   channel  handshake              payload
//   input    in_valid / in_ready    sample_value, block_end
//   output   out_valid / out_ready  packed_value, new_width, block_minimum,
//                                   block_maximum, final_result
//   config   APB psel / penable     paddr, pwdata, prdata (element_width)
//
// One element is taken per cycle while loading. The element ending a block
// is followed by the range calculation state; the first result then passes
// the read and output registers, and more follow one per cycle unless stalled.
// The single read port of the element memory sets the emission rate.
// No input is taken while a block is emitted; the last result may still wait
// in the output register while the next block loads. Output stalls hold the
// emission. Reset returns to loading with an empty block and width code 3.
// ----------------------------------------------------------------------------
module range_contraction_encoder_core import rce_pkg::*; #(
	parameter int BLOCK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] sample_value,
	input  logic        block_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] packed_value,
	output logic [1:0]  new_width,
	output logic [63:0] block_minimum,
	output logic [63:0] block_maximum,
	output logic        final_result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	rce_cmd_t    cmd;
	rce_status_t status;
	logic [1:0]  element_width_q;

	// Configuration register write on the access cycle of an APB transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_width_q <= W64;
		end else if (psel && penable && pwrite && paddr[2] == REG_ELEMENT_WIDTH) begin
			element_width_q <= pwdata[1:0];
		end
	end

	// Register read-back.
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ELEMENT_WIDTH) begin
			prdata = {30'd0, element_width_q};
		end
	end

	assign pready = 1'b1;

	rce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.block_end (block_end),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.status    (status),
		.cmd       (cmd)
	);

	rce_datapath #(
		.BLOCK_DEPTH (BLOCK_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.element_width (element_width_q),
		.sample_value  (sample_value),
		.packed_value  (packed_value),
		.new_width     (new_width),
		.block_minimum (block_minimum),
		.block_maximum (block_maximum),
		.final_result  (final_result)
	);

endmodule

FILE: design/rce_checker.sv
// ----------------------------------------------------------------------------
// rce_checker: port-level checks for the range contraction encoder.
// Watches the input and output channels of the top level over time.
// ----------------------------------------------------------------------------
module rce_checker import rce_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        block_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] packed_value,
	input logic [1:0]  new_width,
	input logic [63:0] block_minimum,
	input logic [63:0] block_maximum,
	input logic        final_result
);

	// A stalled result holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_value)
			&& $stable(final_result))
		else $error("stalled result changed before its transfer");

	// The transfer that ends a block stops further input while it is worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && block_end |=> !in_ready)
		else $error("input taken right after the end of a block");

	// The reported minimum never exceeds the reported maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> block_minimum <= block_maximum)
		else $error("block minimum above block maximum");

	// A result at eight-bit width fits in eight bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_width == W8 |-> packed_value[63:8] == 56'd0)
		else $error("eight-bit result has high bits set");

endmodule

bind range_contraction_encoder_core rce_checker u_rce_checker (.*);
